@@ hdl/assert_macros.svh @@
// Assertion helpers shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, skipped while reset is high.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, skipped while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hdl/brct_pkg.sv @@
package brct_pkg;

   // Field widths fixed by the interface
   localparam int KEY_W   = 10;
   localparam int ID_W    = 32;
   localparam int BATCH_W = 32;
   localparam int OP_W    = 3;

   localparam int NUM_KEYS_DEFAULT = 1024;

   // Opcodes
   localparam logic [OP_W-1:0] OP_RESERVE_READ  = 3'd0;
   localparam logic [OP_W-1:0] OP_RESERVE_WRITE = 3'd1;
   localparam logic [OP_W-1:0] OP_CHECK_WAW     = 3'd2;
   localparam logic [OP_W-1:0] OP_CHECK_RAW     = 3'd3;
   localparam logic [OP_W-1:0] OP_CHECK_WAR     = 3'd4;

   // One table entry: reserver id and its batch
   typedef struct packed {
      logic [ID_W-1:0]    owner;
      logic [BATCH_W-1:0] batch;
   } entry_type;

endpackage

@@ hdl/brct_ram.sv @@
module brct_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port, one registered read port; a read of the address being
   // written returns the old contents.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/batch_reservation_conflict_table_top.sv @@
// Reservation and conflict table. One element is accepted per clock whenever
// busy is low. Its result is on rsp_* with rsp_valid high for a single cycle,
// once the element has passed the read-stage registers and the result
// registers; results come in order. There is no backpressure, so the
// receiver must take every result when it is shown.
// Each element reads both tables; a reservation is a read-modify-write of the
// write table or the read table (synchronous RAMs with a registered read); the
// entry being written back is forwarded to the element that follows, which
// keeps the rate at one element per cycle. After reset busy stays high while a
// clearing pass zeroes both tables, one entry per cycle. Keys at or above
// NUM_KEYS wrap modulo NUM_KEYS. set_conflict collects element conflicts of
// a run and is final on the result that carries last_out.
module batch_reservation_conflict_table_top
   import brct_pkg::*;
#(
   parameter int NUM_KEYS = NUM_KEYS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [OP_W-1:0]    req_opcode,
   input  logic [KEY_W-1:0]   req_key,
   input  logic [ID_W-1:0]    req_txn_id,
   input  logic [BATCH_W-1:0] req_batch_id,
   input  logic               req_last,
   output logic               rsp_valid,
   output logic               rsp_element_conflict,
   output logic               rsp_set_conflict,
   output logic               rsp_last_out
);

   localparam int AW      = $clog2(NUM_KEYS);
   localparam int ENTRY_W = $bits(entry_type);

   logic          accept;
   logic [AW-1:0] key_idx;

   // Clearing pass
   logic          clear_ff,      clear_in;
   logic [AW-1:0] clear_addr_ff, clear_addr_in;

   // Element in the modify stage
   logic               s2_valid_ff;
   logic [OP_W-1:0]    s2_op_ff;
   logic [AW-1:0]      s2_addr_ff;
   logic [ID_W-1:0]    s2_id_ff;
   logic [BATCH_W-1:0] s2_batch_ff;
   logic               s2_last_ff;

   // Forwarding of the last write-back
   logic          fwd_valid_ff,    fwd_valid_in;
   logic          fwd_is_write_ff, fwd_is_write_in;
   logic [AW-1:0] fwd_addr_ff;
   entry_type     fwd_data_ff;

   logic run_conflict_ff, run_conflict_in;

   logic rsp_valid_ff, rsp_elem_ff, rsp_set_ff, rsp_last_ff;
   logic elem_in, set_in;

   // RAM ports
   logic [ENTRY_W-1:0] wtab_rd, rtab_rd;
   logic               wtab_we, rtab_we;
   logic [AW-1:0]      tab_waddr;
   entry_type          tab_wdata;

   entry_type wcur, rcur, sel, upd;
   logic      do_reserve, skip, claim;

   assign busy   = reset | clear_ff;
   assign accept = start & ~busy;

   // Key wrap: reciprocal multiply with one correction step
   generate
      if (NUM_KEYS >= (1 << KEY_W)) begin : g_key_direct
         assign key_idx = AW'(req_key);
      end else begin : g_key_wrap
         localparam int RECIP_SH = 20;
         localparam int RECIP_W  = RECIP_SH + 1;
         localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((1 << RECIP_SH) / NUM_KEYS + 1);
         localparam logic [KEY_W-1:0]   NK    = KEY_W'(NUM_KEYS);
         logic [KEY_W+RECIP_W-1:0] prod;
         logic [KEY_W-1:0]         quo;
         logic [KEY_W-1:0]         rem;
         logic [KEY_W-1:0]         rem_fix;
         assign prod    = (KEY_W + RECIP_W)'(req_key) * (KEY_W + RECIP_W)'(RECIP);
         assign quo     = prod[KEY_W+RECIP_SH-1:RECIP_SH];
         assign rem     = req_key - KEY_W'(quo * NK);
         assign rem_fix = (rem >= NK) ? (rem - NK) : rem;
         assign key_idx = AW'(rem_fix);
      end
   endgenerate

   // Clearing pass after reset
   always_comb begin
      clear_in      = clear_ff;
      clear_addr_in = clear_addr_ff;
      if (clear_ff) begin
         clear_addr_in = clear_addr_ff + AW'(1);
         if (clear_addr_ff == AW'(NUM_KEYS - 1)) begin
            clear_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff      <= 1'b1;
         clear_addr_ff <= '0;
      end else begin
         clear_ff      <= clear_in;
         clear_addr_ff <= clear_addr_in;
      end
   end

   // Read stage: capture the element while the RAMs are read
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= accept;
      end
      if (accept) begin
         s2_op_ff    <= req_opcode;
         s2_addr_ff  <= key_idx;
         s2_id_ff    <= req_txn_id;
         s2_batch_ff <= req_batch_id;
         s2_last_ff  <= req_last;
      end
   end

   // Current entries, with the previous write-back forwarded
   always_comb begin
      wcur = entry_type'(wtab_rd);
      rcur = entry_type'(rtab_rd);
      if (fwd_valid_ff && fwd_addr_ff == s2_addr_ff) begin
         if (fwd_is_write_ff) begin
            wcur = fwd_data_ff;
         end else begin
            rcur = fwd_data_ff;
         end
      end
   end

   // Modify stage: reservation rule and checks
   always_comb begin
      elem_in    = 1'b0;
      do_reserve = 1'b0;
      sel        = rcur;
      unique case (s2_op_ff)
         OP_RESERVE_READ: begin
            do_reserve = 1'b1;
            sel        = rcur;
         end
         OP_RESERVE_WRITE: begin
            do_reserve = 1'b1;
            sel        = wcur;
         end
         OP_CHECK_WAW: begin
            elem_in = (wcur.owner != s2_id_ff) || (wcur.batch != s2_batch_ff);
         end
         OP_CHECK_RAW: begin
            elem_in = (s2_id_ff > wcur.owner) && (wcur.batch == s2_batch_ff) &&
                      (wcur.owner != '0);
         end
         OP_CHECK_WAR: begin
            elem_in = (s2_id_ff > rcur.owner) && (rcur.batch == s2_batch_ff) &&
                      (rcur.owner != '0);
         end
         default: begin
            elem_in = 1'b0;
         end
      endcase

      // Skip when held in this batch by a smaller or equal id
      skip  = (sel.batch == s2_batch_ff) && (sel.owner <= s2_id_ff);
      claim = ~skip && ((sel.owner > s2_id_ff) || (sel.batch < s2_batch_ff) ||
                        (sel.owner == '0));
      upd   = sel;
      if (claim) begin
         upd.owner = s2_id_ff;
         if (sel.batch < s2_batch_ff) begin
            upd.batch = s2_batch_ff;
         end
      end

      set_in          = run_conflict_ff | elem_in;
      run_conflict_in = run_conflict_ff;
      if (s2_valid_ff) begin
         run_conflict_in = s2_last_ff ? 1'b0 : set_in;
      end
   end

   // Write-back port: clearing pass or reservation
   always_comb begin
      wtab_we   = clear_ff | (s2_valid_ff & do_reserve & (s2_op_ff == OP_RESERVE_WRITE));
      rtab_we   = clear_ff | (s2_valid_ff & do_reserve & (s2_op_ff == OP_RESERVE_READ));
      tab_waddr = clear_ff ? clear_addr_ff : s2_addr_ff;
      tab_wdata = clear_ff ? entry_type'('0) : upd;
      fwd_valid_in    = s2_valid_ff & do_reserve;
      fwd_is_write_in = (s2_op_ff == OP_RESERVE_WRITE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_valid_ff    <= 1'b0;
         run_conflict_ff <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         fwd_valid_ff    <= fwd_valid_in;
         run_conflict_ff <= run_conflict_in;
         rsp_valid_ff    <= s2_valid_ff;
      end
      fwd_is_write_ff <= fwd_is_write_in;
      fwd_addr_ff     <= s2_addr_ff;
      fwd_data_ff     <= upd;
      rsp_elem_ff     <= elem_in;
      rsp_set_ff      <= set_in;
      rsp_last_ff     <= s2_last_ff;
   end

   // Write-reservation table
   brct_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (NUM_KEYS)
   ) u_wtab (
      .clock   (clock),
      .wr_en   (wtab_we),
      .wr_addr (tab_waddr),
      .wr_data (tab_wdata),
      .rd_en   (accept),
      .rd_addr (key_idx),
      .rd_data (wtab_rd)
   );

   // Read-reservation table
   brct_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (NUM_KEYS)
   ) u_rtab (
      .clock   (clock),
      .wr_en   (rtab_we),
      .wr_addr (tab_waddr),
      .wr_data (tab_wdata),
      .rd_en   (accept),
      .rd_addr (key_idx),
      .rd_data (rtab_rd)
   );

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_element_conflict = rsp_elem_ff;
   assign rsp_set_conflict     = rsp_set_ff;
   assign rsp_last_out         = rsp_last_ff;

endmodule

@@ hdl/brct_checker.sv @@
`include "assert_macros.svh"

module brct_checker
   import brct_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic [OP_W-1:0]    req_opcode,
   input logic               rsp_valid,
   input logic               rsp_element_conflict,
   input logic               rsp_set_conflict,
   input logic               rsp_last_out
);

   logic accept;
   assign accept = start & ~busy;

   // Each accepted transaction gets a result and each result has a transaction
   `ASSERT_NEXT(a_latency, clock, reset, accept, ##1 rsp_valid,
                "result missing after transaction")
   `ASSERT_IMPLIES(a_no_orphan, clock, reset, rsp_valid, $past(accept, 2),
                   "result without transaction")

   // A flagged element always shows in the running OR
   `ASSERT_IMPLIES(a_set_covers, clock, reset, rsp_valid && rsp_element_conflict,
                   rsp_set_conflict, "set flag misses element conflict")

   // The running OR holds until the run ends
   `ASSERT_IMPLIES(a_set_sticky, clock, reset,
                   (rsp_valid && rsp_set_conflict && !rsp_last_out) ##1 rsp_valid,
                   rsp_set_conflict, "set flag dropped inside run")

   // Reservations never report an element conflict
   `ASSERT_NEXT(a_reserve_clean, clock, reset,
                accept && (req_opcode == OP_RESERVE_READ || req_opcode == OP_RESERVE_WRITE),
                ##1 !rsp_element_conflict, "reservation flagged a conflict")

endmodule

bind batch_reservation_conflict_table_top brct_checker u_brct_checker (.*);

@@ test/testbench.sv @@
module testbench;
   import brct_pkg::*;

   localparam int NUM_KEYS = NUM_KEYS_DEFAULT;
   localparam int HOT_KEYS = 8;
   localparam int ITEM_TARGET = 400;
   localparam int QUIET_TAIL = 60;

   // Opcodes the block leaves without effect on the tables
   localparam logic [OP_W-1:0] OP_SPARE_5 = 3'd5;
   localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
   localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

   typedef struct packed {
      logic element_conflict;
      logic set_conflict;
      logic last_out;
   } verdict_type;

   // Shadow of the reservation tables plus the queue of expected verdicts
   class reservation_board;
      entry_type   write_tab[NUM_KEYS];
      entry_type   read_tab[NUM_KEYS];
      logic        run_hit;
      verdict_type awaited[$];
      int          errors;
      int          checked;
      int          hits;
      int          runs;

      function new();
         for (int i = 0; i < NUM_KEYS; i++) begin
            write_tab[i] = '0;
            read_tab[i]  = '0;
         end
         run_hit = 1'b0;
         errors  = 0;
         checked = 0;
         hits    = 0;
         runs    = 0;
      endfunction

      // Reservation rule: same batch held by a smaller or equal id wins
      function entry_type claimed(entry_type e, logic [ID_W-1:0] id, logic [BATCH_W-1:0] b);
         entry_type n;
         n = e;
         if (e.batch == b && e.owner <= id)
            return e;
         if (e.owner > id || e.batch < b || e.owner == '0) begin
            n.owner = id;
            if (e.batch < b)
               n.batch = b;
         end
         return n;
      endfunction

      // Entry held in this batch by an earlier (smaller, nonzero) id
      function logic earlier_holder(entry_type e, logic [ID_W-1:0] id, logic [BATCH_W-1:0] b);
         return (id > e.owner) && (e.batch == b) && (e.owner != '0);
      endfunction

      function void note_element(logic [OP_W-1:0] op, logic [KEY_W-1:0] key,
                                 logic [ID_W-1:0] id, logic [BATCH_W-1:0] b, logic last);
         int unsigned slot;
         logic        hit;
         verdict_type v;
         slot = int'(key) % NUM_KEYS;
         hit  = 1'b0;
         case (op)
            OP_RESERVE_READ:  read_tab[slot]  = claimed(read_tab[slot], id, b);
            OP_RESERVE_WRITE: write_tab[slot] = claimed(write_tab[slot], id, b);
            OP_CHECK_WAW: begin
               hit = (write_tab[slot].owner != id) || (write_tab[slot].batch != b);
            end
            OP_CHECK_RAW: hit = earlier_holder(write_tab[slot], id, b);
            OP_CHECK_WAR: hit = earlier_holder(read_tab[slot], id, b);
            default: ;
         endcase
         v.element_conflict = hit;
         v.set_conflict     = run_hit | hit;
         v.last_out         = last;
         run_hit = last ? 1'b0 : v.set_conflict;
         if (hit)
            hits++;
         if (last)
            runs++;
         awaited.push_back(v);
      endfunction

      function void check_result(logic ec, logic sc, logic lo);
         verdict_type v;
         if (awaited.size() == 0) begin
            $error("result shown with no element outstanding");
            errors++;
            return;
         end
         v = awaited.pop_front();
         checked++;
         if (ec !== v.element_conflict) begin
            $error("element_conflict: expected %0b, got %0b", v.element_conflict, ec);
            errors++;
         end
         if (sc !== v.set_conflict) begin
            $error("set_conflict: expected %0b, got %0b", v.set_conflict, sc);
            errors++;
         end
         if (lo !== v.last_out) begin
            $error("last_out: expected %0b, got %0b", v.last_out, lo);
            errors++;
         end
      endfunction
   endclass

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic [OP_W-1:0]    req_opcode;
   logic [KEY_W-1:0]   req_key;
   logic [ID_W-1:0]    req_txn_id;
   logic [BATCH_W-1:0] req_batch_id;
   logic               req_last;
   logic               rsp_valid;
   logic               rsp_element_conflict;
   logic               rsp_set_conflict;
   logic               rsp_last_out;

   reservation_board board = new();

   int               sent;
   bit               quiet;
   logic [KEY_W-1:0] hot[HOT_KEYS];
   logic [BATCH_W-1:0] batch_now;

   batch_reservation_conflict_table_top #(
      .NUM_KEYS(NUM_KEYS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_opcode(req_opcode),
      .req_key(req_key),
      .req_txn_id(req_txn_id),
      .req_batch_id(req_batch_id),
      .req_last(req_last),
      .rsp_valid(rsp_valid),
      .rsp_element_conflict(rsp_element_conflict),
      .rsp_set_conflict(rsp_set_conflict),
      .rsp_last_out(rsp_last_out)
   );

   // Clock, period 8
   initial clock = 1'b0;
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Results are taken at the edge that ends their cycle
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1)
         board.check_result(rsp_element_conflict, rsp_set_conflict, rsp_last_out);
   end

   // Drive one element and hold it until accepted; maybe idle afterwards
   task automatic send_element(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
                               input logic [ID_W-1:0] id, input logic [BATCH_W-1:0] b,
                               input logic last);
      req_opcode   <= op;
      req_key      <= key;
      req_txn_id   <= id;
      req_batch_id <= b;
      req_last     <= last;
      start        <= 1'b1;
      do
         @(posedge clock);
      while (busy !== 1'b0);
      board.note_element(op, key, id, b, last);
      sent++;
      if (!quiet && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
   endtask

   // Arbitrary element, any field value
   task automatic send_noise();
      send_element(OP_W'($urandom_range(0, 7)), KEY_W'($urandom), $urandom, $urandom,
                   1'($urandom));
   endtask

   function automatic logic [ID_W-1:0] pick_id();
      int unsigned r;
      r = $urandom_range(0, 39);
      if (r == 0)
         return '0;
      if (r < 5)
         return $urandom;
      return ID_W'($urandom_range(1, 12));
   endfunction

   // One batch round: several transactions reserve, then randomly picked ones of them check
   task automatic run_round();
      logic [ID_W-1:0]    ids[5];
      logic [BATCH_W-1:0] bats[5];
      logic [KEY_W-1:0]   ks[5][4];
      int                 nk[5];
      int                 nt;
      logic [OP_W-1:0]    op;
      if ($urandom_range(0, 2) == 0)
         batch_now++;
      if ($urandom_range(0, 3) == 0)
         hot[$urandom_range(0, HOT_KEYS - 1)] = KEY_W'($urandom);
      nt = $urandom_range(2, 5);
      for (int t = 0; t < nt; t++) begin
         ids[t]  = pick_id();
         bats[t] = batch_now;
         case ($urandom_range(0, 9))
            0: bats[t] = batch_now - 1;
            1: bats[t] = batch_now + 1;
            default: ;
         endcase
         nk[t] = $urandom_range(1, 4);
         for (int k = 0; k < nk[t]; k++)
            ks[t][k] = hot[$urandom_range(0, HOT_KEYS - 1)];
      end
      // reservation phase: each transaction's set ends with last
      for (int t = 0; t < nt; t++) begin
         for (int k = 0; k < nk[t]; k++) begin
            op = $urandom_range(0, 1) ? OP_RESERVE_WRITE : OP_RESERVE_READ;
            send_element(op, ks[t][k], ids[t], bats[t], k == nk[t] - 1);
            if ($urandom_range(0, 11) == 0)
               send_noise();
         end
      end
      // check phase: transactions picked at random, repeats allowed
      for (int t = 0; t < nt; t++) begin
         int u;
         u = $urandom_range(0, nt - 1);
         for (int k = 0; k < nk[u]; k++) begin
            case ($urandom_range(0, 2))
               0: op = OP_CHECK_WAW;
               1: op = OP_CHECK_RAW;
               default: op = OP_CHECK_WAR;
            endcase
            send_element(op, ks[u][k], ids[u], bats[u], k == nk[u] - 1);
            if ($urandom_range(0, 11) == 0)
               send_noise();
         end
      end
   endtask

   initial begin
      reset        = 1'b1;
      start        = 1'b0;
      req_opcode   = OP_RESERVE_READ;
      req_key      = '0;
      req_txn_id   = '0;
      req_batch_id = '0;
      req_last     = 1'b0;
      sent         = 0;
      quiet        = 1'b0;
      batch_now    = BATCH_W'($urandom_range(0, 3));
      hot[0] = '0;
      hot[1] = '1;
      for (int i = 2; i < HOT_KEYS; i++)
         hot[i] = KEY_W'($urandom);
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty entry, claim and skip rules, runs, extremes, spare opcodes
      send_element(OP_CHECK_WAW,     10'd0,    32'd0,        32'd0,        1'b1);
      send_element(OP_RESERVE_WRITE, 10'd0,    32'd5,        32'd7,        1'b0);
      send_element(OP_RESERVE_WRITE, 10'd0,    32'd3,        32'd7,        1'b0);
      send_element(OP_RESERVE_WRITE, 10'd0,    32'd9,        32'd7,        1'b1);
      send_element(OP_CHECK_WAW,     10'd0,    32'd3,        32'd7,        1'b0);
      send_element(OP_CHECK_RAW,     10'd0,    32'd4,        32'd7,        1'b0);
      send_element(OP_CHECK_WAR,     10'd0,    32'd4,        32'd7,        1'b1);
      send_element(OP_RESERVE_READ,  10'd1023, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1);
      send_element(OP_RESERVE_READ,  10'd1023, 32'd1,        32'd0,        1'b0);
      send_element(OP_CHECK_WAR,     10'd1023, 32'd2,        32'hFFFFFFFF, 1'b1);
      send_element(OP_CHECK_WAR,     10'd1023, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1);
      // zero transaction id
      send_element(OP_RESERVE_WRITE, 10'd512,  32'd0,        32'd1,        1'b0);
      send_element(OP_CHECK_RAW,     10'd512,  32'd0,        32'd1,        1'b0);
      send_element(OP_CHECK_WAW,     10'd512,  32'd0,        32'd1,        1'b1);
      send_element(OP_RESERVE_WRITE, 10'd512,  32'd6,        32'd1,        1'b1);
      // run carried through spare opcodes
      send_element(OP_CHECK_WAW,     10'd1,    32'd1,        32'd0,        1'b0);
      send_element(OP_SPARE_5,       10'd1,    32'd1,        32'd0,        1'b0);
      send_element(OP_SPARE_6,       10'd1023, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1);
      send_element(OP_SPARE_7,       10'd0,    32'd0,        32'd0,        1'b1);
      send_element(OP_CHECK_RAW,     10'd1,    32'd1,        32'd0,        1'b1);

      // Random batch rounds, the tail without idling
      while (sent < ITEM_TARGET - QUIET_TAIL)
         run_round();
      quiet = 1'b1;
      while (sent < ITEM_TARGET)
         run_round();
      start <= 1'b0;

      // Drain, then allow the pipeline to settle
      while (board.awaited.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);

      $display("summary: %0d elements sent, %0d results checked, %0d conflicting elements",
               sent, board.checked, board.hits);
      $display("summary: %0d runs closed by last", board.runs);
      if (board.errors == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #(8 * 300000);
      $display("testbench: FAIL");
      $finish;
   end

endmodule
